// File: rtl/core/assert_macros.svh
// Assertion helpers shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, masked during reset
`define ASE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ase_pkg.sv
package ase_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned AddrW  = 10;
    localparam int unsigned CountW = 11;
    localparam int unsigned Depth  = 1024;

    typedef enum logic [1:0] {
        MODE_LINEAR = 2'd0,
        MODE_BINARY = 2'd1,
        MODE_INTERP = 2'd2
    } mode_t;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic               command;
        logic [1:0]         mode;
        logic [AddrW-1:0]   address;
        logic signed [WordW-1:0] value;
        logic signed [WordW-1:0] key;
        logic [CountW-1:0]  count;
        logic [AddrW-1:0]   low_index;
        logic [AddrW-1:0]   high_index;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic [AddrW-1:0] position;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIN_RD,
        ST_LIN_CMP,
        ST_RD_ENDS,
        ST_LATCH_LO,
        ST_LATCH_HI,
        ST_CHECK,
        ST_DIV,
        ST_DIV_WAIT,
        ST_PROBE_RD,
        ST_PROBE_CMP,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;    // capture item, init loop registers
        logic lin_step;     // advance linear index
        logic rd_lo;        // read store at lo
        logic rd_hi;        // read store at hi
        logic latch_lo;
        logic latch_hi;
        logic div_start;
        logic mid_bisect;   // probe at (lo+hi)/2
        logic mid_low;      // probe at lo
        logic mid_interp;   // probe at lo + quotient
        logic rd_mid;
        logic narrow;       // update lo/hi from probe compare
        logic set_found;    // found at probe index
        logic set_found_lo; // found at lo
        logic set_found_lin;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic       is_search;
        logic [1:0] mode;
        logic       lin_done;   // index reached limit
        logic       lin_match;
        logic       range_ok;   // lo <= hi
        logic       key_in;     // a[lo] <= key <= a[hi]
        logic       lo_eq_hi;
        logic       ends_eq;
        logic       lo_match;
        logic       div_busy;
        logic       probe_eq;
    } sts_t;

endpackage

// File: rtl/core/ase_ram.sv
module ase_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/ase_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
module ase_div #(
    parameter int unsigned NW = 43,
    parameter int unsigned DW = 33
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quo
);

    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    always_comb
    begin
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        trial    = {r_reg[DW-1:0], q_reg[NW-1]};
        diff     = trial - {1'b0, d_reg};
        if (start)
        begin
            q_next   = num;
            r_next   = '0;
            d_next   = den;
            cnt_next = CW'(NW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!diff[DW])
            begin
                r_next = diff;
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = (cnt_reg != '0);
    assign quo  = q_reg;

endmodule

// File: rtl/core/ase_datapath.sv
module ase_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  ase_pkg::in_item_t  item,
    input  ase_pkg::ctl_t      ctl,
    output ase_pkg::sts_t      sts,
    output ase_pkg::out_item_t result
);

    localparam int unsigned DEPTH = ase_pkg::Depth;
    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned PW = 34 + IW;   // (key-alo)*(hi-lo), unsigned
    localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);

    ase_pkg::in_item_t item_reg;
    logic [IW:0]       lin_reg, lin_next;
    logic [IW:0]       lin_lim;
    logic [IW:0]       lo_reg, lo_next;
    logic signed [IW+1:0] hi_reg, hi_next;  // may go to lo-1
    logic [IW-1:0]     mid_reg, mid_next;
    logic signed [32:0] alo_reg, ahi_reg;
    logic [PW-1:0]     prod_reg;
    logic              found_reg, found_next;
    logic [IW-1:0]     pos_reg, pos_next;
    logic              we;
    logic [IW-1:0]     raddr;
    logic [31:0]       rdata;
    logic signed [32:0] rd_s;
    logic signed [32:0] key_s;
    logic [32:0]       kdiff;
    logic [32:0]       ddiff;
    logic [IW-1:0]     span;
    logic              div_busy;
    logic [PW-1:0]     quo;
    logic [IW:0]       bis;
    logic [IW:0]       addr_ext;
    logic [IW:0]       hi_clamp;
    logic [IW-1:0]     interp_mid;

    assign key_s = {item_reg.key[31], item_reg.key};
    assign rd_s  = {rdata[31], rdata};
    assign we    = ctl.load_item && (item.command == ase_pkg::CMD_LOAD)
                   && ({1'b0, item.address} < 11'(DEPTH));
    assign lin_lim = (item_reg.count > 11'(DEPTH)) ? (IW+1)'(DEPTH)
                                                     : (IW+1)'(item_reg.count);
    assign bis = (lo_reg + hi_reg[IW:0]) >> 1;
    assign addr_ext = (IW+1)'(item.address);

    always_comb
    begin
        raddr = lin_reg[IW-1:0];
        if (ctl.rd_lo)
        begin
            raddr = lo_reg[IW-1:0];
        end
        else if (ctl.rd_hi)
        begin
            raddr = hi_reg[IW-1:0];
        end
        else if (ctl.rd_mid)
        begin
            raddr = mid_reg;
        end
    end

    ase_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (addr_ext[IW-1:0]),
        .wdata (item.value),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign kdiff = 33'(key_s - alo_reg);
    assign ddiff = 33'(ahi_reg - alo_reg);
    assign span  = IW'(hi_reg[IW:0] - lo_reg);

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(kdiff) * PW'(span);
    end

    ase_div #(.NW(PW), .DW(33)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (prod_reg),
        .den   (ddiff),
        .busy  (div_busy),
        .quo   (quo)
    );

    // interpolation probe index taken once the divider finishes
    assign interp_mid = IW'(lo_reg + quo[IW:0]);

    always_comb
    begin
        hi_clamp = ({1'b0, item.high_index} > (IW+1)'(DEPTH - 1))
                   ? {1'b0, LastIdx} : (IW+1)'(item.high_index);
        lin_next   = lin_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        if (ctl.load_item)
        begin
            lin_next   = '0;
            lo_next    = (IW+1)'(item.low_index);
            hi_next    = (IW+2)'(hi_clamp);
            found_next = 1'b0;
            pos_next   = '0;
        end
        if (ctl.lin_step)
        begin
            lin_next = lin_reg + 1'b1;
        end
        if (ctl.mid_bisect)
        begin
            mid_next = bis[IW-1:0];
        end
        else if (ctl.mid_low)
        begin
            mid_next = lo_reg[IW-1:0];
        end
        else if (ctl.mid_interp)
        begin
            mid_next = interp_mid;
        end
        if (ctl.narrow)
        begin
            if (rd_s > key_s)
            begin
                hi_next = $signed({2'b00, mid_reg} - (IW+2)'(1));
            end
            else
            begin
                lo_next = (IW+1)'(mid_reg) + 1'b1;
            end
        end
        if (ctl.set_found)
        begin
            found_next = 1'b1;
            pos_next   = mid_reg;
        end
        if (ctl.set_found_lo)
        begin
            found_next = 1'b1;
            pos_next   = lo_reg[IW-1:0];
        end
        if (ctl.set_found_lin)
        begin
            found_next = 1'b1;
            pos_next   = lin_reg[IW-1:0] - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            item_reg <= item;
        end
        lin_reg <= lin_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        if (ctl.latch_lo)
        begin
            alo_reg <= rd_s;
        end
        if (ctl.latch_hi)
        begin
            ahi_reg <= rd_s;
        end
        pos_reg <= pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    assign sts.is_search = (item_reg.command == ase_pkg::CMD_SEARCH);
    assign sts.mode      = item_reg.mode;
    assign sts.lin_done  = (lin_reg >= lin_lim);
    assign sts.lin_match = (rd_s == key_s);
    assign sts.range_ok  = ($signed({1'b0, lo_reg}) <= hi_reg);
    assign sts.key_in    = (key_s >= alo_reg) && (key_s <= ahi_reg);
    assign sts.lo_eq_hi  = ($signed({1'b0, lo_reg}) == hi_reg);
    assign sts.ends_eq   = (ahi_reg == alo_reg);
    assign sts.lo_match  = (alo_reg == key_s);
    assign sts.div_busy  = div_busy;
    assign sts.probe_eq  = (rd_s == key_s);

    assign result.found    = found_reg;
    assign result.position = pos_reg;

endmodule

// File: rtl/core/ase_ctrl.sv
module ase_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ase_pkg::sts_t sts,
    output ase_pkg::ctl_t ctl,
    output logic          busy,
    output logic          done
);

    ase_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ase_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        busy       = (state_reg != ase_pkg::ST_IDLE);
        done       = 1'b0;
        case (state_reg)
            ase_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = ase_pkg::ST_CHECK;
                end
            end
            ase_pkg::ST_CHECK:
            begin
                // dispatch on captured item
                if (!sts.is_search)
                begin
                    state_next = ase_pkg::ST_DONE;
                end
                else if (sts.mode == ase_pkg::MODE_LINEAR)
                begin
                    state_next = ase_pkg::ST_LIN_RD;
                end
                else if ((sts.mode == ase_pkg::MODE_BINARY) && sts.range_ok)
                begin
                    ctl.mid_bisect = 1'b1;
                    state_next     = ase_pkg::ST_PROBE_RD;
                end
                else if ((sts.mode == ase_pkg::MODE_INTERP) && sts.range_ok)
                begin
                    state_next = ase_pkg::ST_RD_ENDS;
                end
                else
                begin
                    state_next = ase_pkg::ST_DONE;
                end
            end
            ase_pkg::ST_LIN_RD:
            begin
                if (sts.lin_done)
                begin
                    state_next = ase_pkg::ST_DONE;
                end
                else
                begin
                    ctl.lin_step = 1'b1;
                    state_next   = ase_pkg::ST_LIN_CMP;
                end
            end
            ase_pkg::ST_LIN_CMP:
            begin
                if (sts.lin_match)
                begin
                    ctl.set_found_lin = 1'b1;
                    state_next        = ase_pkg::ST_DONE;
                end
                else
                begin
                    state_next = ase_pkg::ST_LIN_RD;
                end
            end
            ase_pkg::ST_RD_ENDS:
            begin
                ctl.rd_lo  = 1'b1;
                state_next = ase_pkg::ST_LATCH_LO;
            end
            ase_pkg::ST_LATCH_LO:
            begin
                ctl.latch_lo = 1'b1;
                ctl.rd_hi    = 1'b1;
                state_next   = ase_pkg::ST_LATCH_HI;
            end
            ase_pkg::ST_LATCH_HI:
            begin
                ctl.latch_hi = 1'b1;
                state_next   = ase_pkg::ST_DIV;
            end
            ase_pkg::ST_DIV:
            begin
                // product register already holds (key-a[lo])*(hi-lo)
                if (!sts.key_in)
                begin
                    state_next = ase_pkg::ST_DONE;
                end
                else if (sts.lo_eq_hi)
                begin
                    ctl.set_found_lo = sts.lo_match;
                    state_next       = ase_pkg::ST_DONE;
                end
                else if (sts.ends_eq)
                begin
                    ctl.mid_low = 1'b1;
                    state_next  = ase_pkg::ST_PROBE_RD;
                end
                else
                begin
                    ctl.div_start = 1'b1;
                    state_next    = ase_pkg::ST_DIV_WAIT;
                end
            end
            ase_pkg::ST_DIV_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    ctl.mid_interp = 1'b1;
                    state_next     = ase_pkg::ST_PROBE_RD;
                end
            end
            ase_pkg::ST_PROBE_RD:
            begin
                ctl.rd_mid = 1'b1;
                state_next = ase_pkg::ST_PROBE_CMP;
            end
            ase_pkg::ST_PROBE_CMP:
            begin
                ctl.rd_mid = 1'b1;
                if (sts.probe_eq)
                begin
                    ctl.set_found = 1'b1;
                    state_next    = ase_pkg::ST_DONE;
                end
                else
                begin
                    ctl.narrow = 1'b1;
                    state_next = ase_pkg::ST_CHECK;
                end
            end
            ase_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = ase_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ase_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/array_search_engine_core.sv
// Channel   Handshake            Payload
// command   start / busy         item   (ase_pkg::in_item_t)
// result    done (one cycle)     result (ase_pkg::out_item_t)
//
// A load passes the check and done states; linear search visits a read and a
// compare state per scanned entry. Binary search: each bisection step passes the
// check, probe-read and probe-compare states. Interpolation: store reads of both
// range ends, then, unless they match, the restoring divider, 1 bit per cycle.
// Reset clears the controller and flags; store contents stay undefined.
// The receiver cannot stall: done pulses for one cycle with the result.
module array_search_engine_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ase_pkg::in_item_t  item,
    output logic               busy,
    output logic               done,
    output ase_pkg::out_item_t result
);

    ase_pkg::ctl_t ctl;
    ase_pkg::sts_t sts;

    ase_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    ase_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .ctl    (ctl),
        .sts    (sts),
        .result (result)
    );

endmodule

// File: rtl/core/ase_checker.sv
`include "assert_macros.svh"

module ase_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input ase_pkg::out_item_t result
);

    `ASE_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy, "no busy after beat")
    `ASE_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy, "done while idle")
    `ASE_ASSERT_NXT(a_done_free, clk, rst_n, done, !busy, "busy after done")
    `ASE_ASSERT_IMP(a_nf_pos, clk, rst_n, done && !result.found, result.position == '0,
        "not found with nonzero position")

endmodule

bind array_search_engine_core ase_checker u_ase_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: tb/array_search_engine_core_test.sv
`timescale 1ns / 100ps

module array_search_engine_core_test;

    localparam int Depth = int'(ase_pkg::Depth);
    localparam int AddrW = int'(ase_pkg::AddrW);
    localparam int CountW = int'(ase_pkg::CountW);
    // entries written by the fill; the random searches stay inside them
    localparam int Filled = 256;
    localparam int CycleLimit = 20000000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               start;
    ase_pkg::in_item_t  item;
    logic               busy;
    logic               done;
    ase_pkg::out_item_t result;

    array_search_engine_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    logic signed [31:0] mirror_store [Depth];
    ase_pkg::out_item_t pending_answers [$];
    int                 errors = 0;
    int                 cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("array_search_engine_core_test: done, errors");
            $finish;
        end
    end

    function automatic longint find_linear(longint key, int count);
        int n;
        n = (count > Depth) ? Depth : count;
        for (int i = 0; i < n; i++)
            if (longint'(mirror_store[i]) == key)
                return i;
        return -1;
    endfunction

    function automatic longint find_bisect(longint key, longint lo, longint hi);
        longint mid;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (longint'(mirror_store[mid]) > key)
                hi = mid - 1;
            else if (longint'(mirror_store[mid]) == key)
                return mid;
            else
                lo = mid + 1;
        end
        return -1;
    endfunction

    function automatic longint find_interp(longint key, longint lo, longint hi);
        longint alo;
        longint ahi;
        longint mid;
        longint v;
        while (lo <= hi && key >= longint'(mirror_store[lo])
               && key <= longint'(mirror_store[hi]))
        begin
            alo = mirror_store[lo];
            ahi = mirror_store[hi];
            if (lo == hi)
                return (alo == key) ? lo : -1;
            if (ahi == alo)
                mid = lo;
            else
                mid = lo + ((key - alo) * (hi - lo)) / (ahi - alo);
            v = mirror_store[mid];
            if (v > key)
                hi = mid - 1;
            else if (v == key)
                return mid;
            else
                lo = mid + 1;
        end
        return -1;
    endfunction

    // Updates the mirror on loads and returns the answer the block should give.
    function automatic ase_pkg::out_item_t search_answer(ase_pkg::in_item_t it);
        ase_pkg::out_item_t r;
        longint    pos;
        longint    lo;
        longint    hi;
        pos = -1;
        lo = it.low_index;
        hi = it.high_index;
        if (hi > Depth - 1)
            hi = Depth - 1;
        if (it.command == ase_pkg::CMD_LOAD)
        begin
            if (it.address < Depth)
                mirror_store[it.address] = it.value;
        end
        else if (it.mode == ase_pkg::MODE_LINEAR)
            pos = find_linear(longint'(it.key), it.count);
        else if (it.mode == ase_pkg::MODE_BINARY && lo <= Depth - 1)
            pos = find_bisect(longint'(it.key), lo, hi);
        else if (it.mode == ase_pkg::MODE_INTERP && lo <= Depth - 1)
            pos = find_interp(longint'(it.key), lo, hi);
        r.found = (pos >= 0);
        r.position = (pos >= 0) ? pos[AddrW-1:0] : '0;
        return r;
    endfunction

    function automatic ase_pkg::in_item_t load_beat(int addr, logic signed [31:0] val);
        ase_pkg::in_item_t it;
        it = ase_pkg::in_item_t'($urandom());
        it.command = ase_pkg::CMD_LOAD;
        it.address = AddrW'(addr);
        it.value = val;
        return it;
    endfunction

    function automatic ase_pkg::in_item_t search_beat(logic [1:0] mode,
                                                      logic signed [31:0] key,
                                                      int count, int lo, int hi);
        ase_pkg::in_item_t it;
        it = ase_pkg::in_item_t'({$urandom(), $urandom(), $urandom()});
        it.command = ase_pkg::CMD_SEARCH;
        it.mode = mode;
        it.key = key;
        it.count = CountW'(count);
        it.low_index = AddrW'(lo);
        it.high_index = AddrW'(hi);
        return it;
    endfunction

    task automatic send_beat(ase_pkg::in_item_t it);
        int  gap;
        logic was_busy;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        forever
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
            if (!was_busy)
                break;
        end
        pending_answers.push_back(search_answer(it));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result found=%0d position=%0d",
                         $realtime, result.found, result.position);
                errors++;
            end
            else
            begin
                ase_pkg::out_item_t e;
                e = pending_answers.pop_front();
                if (result.found !== e.found)
                begin
                    $display("%0t: found expected %0d actual %0d",
                             $realtime, e.found, result.found);
                    errors++;
                end
                if (result.position !== e.position)
                begin
                    $display("%0t: position expected %0d actual %0d",
                             $realtime, e.position, result.position);
                    errors++;
                end
            end
        end
    end

    // Sorted fill spanning the whole signed range, extremes at both ends.
    task automatic test_fill_store();
        logic signed [31:0] v;
        for (int i = 0; i < Filled; i++)
        begin
            v = -32'sd2147483648 + i * 16777216 + $urandom_range(0, 16777215);
            if (i == 0)
                v = -32'sd2147483648;
            if (i == Filled - 1)
                v = 32'sd2147483647;
            send_beat(load_beat(i, v));
        end
    endtask

    task automatic test_linear_edges();
        send_beat(search_beat(ase_pkg::MODE_LINEAR, mirror_store[0], 0, 0, 0));
        send_beat(search_beat(ase_pkg::MODE_LINEAR, mirror_store[0], 1, 0, 0));
        send_beat(search_beat(ase_pkg::MODE_LINEAR, 32'sd2147483647, 1024, 0, 0));
        send_beat(search_beat(ase_pkg::MODE_LINEAR, 32'sd2147483647, 2047, 0, 0));
        send_beat(search_beat(ase_pkg::MODE_LINEAR, mirror_store[200] + 1, Filled, 0, 0));
        send_beat(search_beat(MODE_UNUSED, mirror_store[5], 1024, 0, 1023));
    endtask

    task automatic test_range_edges();
        send_beat(search_beat(ase_pkg::MODE_BINARY, -32'sd2147483648, 0, 0, Filled - 1));
        send_beat(search_beat(ase_pkg::MODE_BINARY, 32'sd2147483647, 0, 0, Filled - 1));
        send_beat(search_beat(ase_pkg::MODE_BINARY, mirror_store[150], 0, 200, 100));
        send_beat(search_beat(ase_pkg::MODE_BINARY, mirror_store[77], 0, 77, 77));
        send_beat(search_beat(ase_pkg::MODE_BINARY, mirror_store[140] + 1, 0, 0, Filled - 1));
        send_beat(search_beat(ase_pkg::MODE_INTERP, -32'sd2147483648, 0, 0, Filled - 1));
        send_beat(search_beat(ase_pkg::MODE_INTERP, 32'sd2147483647, 0, 0, Filled - 1));
        send_beat(search_beat(ase_pkg::MODE_INTERP, mirror_store[133], 0, 0, Filled - 1));
        send_beat(search_beat(ase_pkg::MODE_INTERP, mirror_store[10], 0, 20, 30));
        send_beat(search_beat(ase_pkg::MODE_INTERP, mirror_store[50], 0, 60, 40));
        send_beat(search_beat(ase_pkg::MODE_INTERP, mirror_store[200], 0, 200, 200));
    endtask

    // Flat run so both range ends hold the same word.
    task automatic test_interp_flat();
        logic signed [31:0] v;
        v = mirror_store[100];
        for (int i = 101; i <= 103; i++)
            send_beat(load_beat(i, v));
        send_beat(search_beat(ase_pkg::MODE_INTERP, v, 0, 100, 103));
        send_beat(search_beat(ase_pkg::MODE_INTERP, v, 0, 101, 103));
        send_beat(search_beat(ase_pkg::MODE_LINEAR, v, 200, 0, 0));
    endtask

    task automatic test_random();
        ase_pkg::in_item_t  it;
        int                 a;
        int                 lo;
        int                 hi;
        int                 sel;
        longint             lb;
        longint             ub;
        logic [1:0]         mode;
        logic signed [31:0] key;
        for (int n = 0; n < 300; n++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                a = $urandom_range(0, Filled - 1);
                if ($urandom_range(0, 3) != 0)
                begin
                    // keep the store sorted around the written entry
                    lb = (a == 0) ? -64'sd2147483648 : longint'(mirror_store[a - 1]);
                    ub = (a == Filled - 1) ? 64'sd2147483647
                                           : longint'(mirror_store[a + 1]);
                    if (ub < lb)
                        ub = lb;
                    it = load_beat(a, 32'(lb + longint'($urandom()) % (ub - lb + 1)));
                end
                else
                    it = load_beat(a, $urandom());
            end
            else
            begin
                sel = $urandom_range(0, 9);
                mode = (sel < 3) ? ase_pkg::MODE_LINEAR : (sel < 6) ? ase_pkg::MODE_BINARY
                     : (sel < 9) ? ase_pkg::MODE_INTERP : MODE_UNUSED;
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    key = mirror_store[$urandom_range(0, Filled - 1)];
                else if (sel < 8)
                    key = mirror_store[$urandom_range(0, Filled - 1)] + 1;
                else
                    key = $urandom();
                if ($urandom_range(0, 7) == 0)
                begin
                    lo = $urandom_range(0, Filled - 1);
                    hi = $urandom_range(0, Filled - 1);
                end
                else
                begin
                    lo = $urandom_range(0, Filled - 1);
                    hi = lo + $urandom_range(0, 63);
                    if (hi > Filled - 1)
                        hi = Filled - 1;
                end
                it = search_beat(mode, key, $urandom_range(0, Filled), lo, hi);
            end
            send_beat(it);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_store();
        test_linear_edges();
        test_range_edges();
        test_interp_flat();
        test_random();
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("array_search_engine_core_test: done, clean");
        else
            $display("array_search_engine_core_test: done, errors");
        $finish;
    end

endmodule
